@@ hdl/o64fr_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the frame receiver.
package o64fr_pkg;

	localparam int FRAME_DEPTH = 64;
	localparam int IDX_W       = $clog2(FRAME_DEPTH + 1);
	localparam int ADDR_W      = $clog2(FRAME_DEPTH);
	localparam int SUM_W       = 12;

	localparam logic [7:0] CH_START     = 8'h23;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_OFFSET    = 8'h3D;
	localparam logic [7:0] CH_ADDR_BASE = 8'h61;
	localparam logic [7:0] CH_RESET     = 8'h52;

	// '#', address, command and two checksum characters
	localparam logic [IDX_W-1:0] MIN_FILL       = IDX_W'(5);
	// smallest fill that holds one full payload group
	localparam logic [IDX_W-1:0] FIRST_GRP_FILL = IDX_W'(9);
	localparam logic [IDX_W-1:0] PAYLOAD_START  = IDX_W'(3);

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_CK  = 2'd1,
		ST_OVERRUN = 2'd2,
		ST_SHORT   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OUT_STATUS,
		OUT_EMPTY,
		OUT_DATA
	} out_kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_READ,
		S_DRAIN,
		S_EMIT,
		S_STATUS,
		S_EMPTY
	} state_t;

	typedef struct packed {
		logic      start;
		logic      append;
		logic      restart;
		logic      rd_first;
		logic      rd_en;
		logic      out_load;
		out_kind_t kind;
		status_t   status;
		logic [1:0] sel;
		logic      last;
	} dp_cmd_t;

	typedef struct packed {
		logic in_frame;
		logic full;
		logic is_start;
		logic is_cr;
		logic too_short;
		logic ck_ok;
		logic no_groups;
		logic last_group;
		logic out_free;
	} dp_sts_t;

endpackage

@@ hdl/o64fr_ctrl.sv @@
// Controller state machine: byte intake, frame close, group read and result sequencing.
module o64fr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	output logic               rx_ready,
	input  o64fr_pkg::dp_sts_t sts,
	output o64fr_pkg::dp_cmd_t cmd
);
	import o64fr_pkg::*;

	state_t     state_q, state_n;
	logic [1:0] cnt_q, cnt_n;
	status_t    stat_q, stat_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			stat_q  <= ST_OK;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
			stat_q  <= stat_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		cnt_n    = cnt_q;
		stat_n   = stat_q;
		rx_ready = 1'b0;
		cmd      = '0;
		cmd.kind   = OUT_STATUS;
		cmd.status = stat_q;
		cmd.sel    = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				rx_ready = 1'b1;
				if (rx_valid) begin
					if (!sts.in_frame) begin
						cmd.start = sts.is_start;
					end else if (sts.full) begin
						stat_n  = ST_OVERRUN;
						state_n = S_STATUS;
					end else if (sts.is_cr) begin
						if (sts.too_short) begin
							stat_n  = ST_SHORT;
							state_n = S_STATUS;
						end else begin
							state_n = S_CHECK;
						end
					end else begin
						cmd.append = 1'b1;
					end
				end
			end
			S_CHECK: begin
				if (!sts.ck_ok) begin
					stat_n  = ST_BAD_CK;
					state_n = S_STATUS;
				end else if (sts.no_groups) begin
					state_n = S_EMPTY;
				end else begin
					cmd.rd_first = 1'b1;
					cnt_n        = '0;
					state_n      = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				cnt_n     = cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					state_n = S_DRAIN;
				end
			end
			S_DRAIN: begin
				cnt_n   = '0;
				state_n = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.kind     = OUT_DATA;
					cmd.last     = (cnt_q == 2'd2) && sts.last_group;
					cnt_n        = cnt_q + 2'd1;
					if (cnt_q == 2'd2) begin
						cnt_n = '0;
						if (sts.last_group) begin
							cmd.restart = 1'b1;
							state_n     = S_IDLE;
						end else begin
							state_n = S_READ;
						end
					end
				end
			end
			S_STATUS: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.kind     = OUT_STATUS;
					cmd.restart  = 1'b1;
					state_n      = S_IDLE;
				end
			end
			S_EMPTY: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.kind     = OUT_EMPTY;
					cmd.restart  = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

endmodule

@@ hdl/o64fr_dp.sv @@
// Datapath: frame store, running sum, checksum compare, group unpack and result register.
module o64fr_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         rx_byte,
	input  o64fr_pkg::dp_cmd_t cmd,
	output o64fr_pkg::dp_sts_t sts,
	input  logic               res_ready,
	output logic               res_valid,
	output logic [7:0]         frame_address,
	output logic [7:0]         frame_command,
	output logic [7:0]         payload_byte,
	output logic               payload_valid,
	output logic [1:0]         frame_status,
	output logic               reset_request,
	output logic               last_of_frame
);
	import o64fr_pkg::*;

	logic [7:0]       frame_mem [FRAME_DEPTH];
	logic [IDX_W-1:0] fill_q;
	logic [SUM_W-1:0] sum_q;
	logic             in_frame_q;
	logic [7:0]       last1_q, last2_q;
	logic [7:0]       addr_q, cmd_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic [7:0]       rd_data_q;
	logic             rd_vld_s1;
	logic [31:0]      grp_q;
	logic             res_valid_q;

	logic [SUM_W-1:0] ck_sum;
	logic [7:0]       ck_hi, ck_lo;
	logic [7:0]       ga, gb, gc, gd;
	logic [7:0]       byte_x, byte_y, byte_z, byte_sel;
	logic             wr_en;
	logic [ADDR_W-1:0] wr_addr;

	assign wr_en   = cmd.start || cmd.append;
	assign wr_addr = cmd.start ? '0 : fill_q[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			frame_mem[wr_addr] <= rx_byte;
		end
		if (cmd.rd_en) begin
			rd_data_q <= frame_mem[rd_ptr_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			sum_q       <= '0;
			in_frame_q  <= 1'b0;
			rd_vld_s1   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			if (cmd.restart) begin
				fill_q     <= '0;
				sum_q      <= '0;
				in_frame_q <= 1'b0;
			end else if (cmd.start) begin
				fill_q     <= IDX_W'(1);
				sum_q      <= SUM_W'(CH_START);
				in_frame_q <= 1'b1;
			end else if (cmd.append) begin
				fill_q <= fill_q + IDX_W'(1);
				sum_q  <= sum_q + SUM_W'(rx_byte);
			end
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// track the last two stored characters and the header fields as they go by
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			last1_q <= rx_byte;
		end else if (cmd.append) begin
			last2_q <= last1_q;
			last1_q <= rx_byte;
			if (fill_q == IDX_W'(1)) begin
				addr_q <= rx_byte - CH_ADDR_BASE;
			end
			if (fill_q == IDX_W'(2)) begin
				cmd_q <= rx_byte;
			end
		end
		if (cmd.rd_first) begin
			rd_ptr_q <= PAYLOAD_START;
		end else if (cmd.rd_en) begin
			rd_ptr_q <= rd_ptr_q + IDX_W'(1);
		end
		if (rd_vld_s1) begin
			grp_q <= {grp_q[23:0], rd_data_q - CH_OFFSET};
		end
	end

	assign ck_sum = sum_q - SUM_W'(last2_q) - SUM_W'(last1_q);
	assign ck_hi  = CH_OFFSET + 8'(ck_sum[11:6]);
	assign ck_lo  = CH_OFFSET + 8'(ck_sum[5:0]);

	assign ga = grp_q[31:24];
	assign gb = grp_q[23:16];
	assign gc = grp_q[15:8];
	assign gd = grp_q[7:0];
	assign byte_x = {ga[5:0], 2'b00} | {4'b0000, gb[7:4]};
	assign byte_y = {gb[3:0], 4'b0000} | {2'b00, gc[7:2]};
	assign byte_z = {gc[1:0], 6'b000000} | gd;

	always_comb begin
		case (cmd.sel)
			2'd0:    byte_sel = byte_x;
			2'd1:    byte_sel = byte_y;
			default: byte_sel = byte_z;
		endcase
	end

	always_comb begin
		sts.in_frame  = in_frame_q;
		sts.full      = fill_q >= IDX_W'(FRAME_DEPTH);
		sts.is_start  = rx_byte == CH_START;
		sts.is_cr     = rx_byte == CH_CR;
		sts.too_short = fill_q < MIN_FILL;
		sts.ck_ok     = (ck_hi == last2_q) && (ck_lo == last1_q);
		sts.no_groups = fill_q < FIRST_GRP_FILL;
		// another group fits when its last character sits before the checksum
		sts.last_group = ({1'b0, rd_ptr_q} + (IDX_W+1)'(6)) > {1'b0, fill_q};
		sts.out_free  = !res_valid_q || res_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			unique case (cmd.kind)
				OUT_STATUS: begin
					frame_address <= '0;
					frame_command <= '0;
					payload_byte  <= '0;
					payload_valid <= 1'b0;
					frame_status  <= cmd.status;
					reset_request <= 1'b0;
					last_of_frame <= 1'b1;
				end
				OUT_EMPTY: begin
					frame_address <= addr_q;
					frame_command <= cmd_q;
					payload_byte  <= '0;
					payload_valid <= 1'b0;
					frame_status  <= ST_OK;
					reset_request <= cmd_q == CH_RESET;
					last_of_frame <= 1'b1;
				end
				default: begin
					frame_address <= addr_q;
					frame_command <= cmd_q;
					payload_byte  <= byte_sel;
					payload_valid <= 1'b1;
					frame_status  <= ST_OK;
					reset_request <= cmd_q == CH_RESET;
					last_of_frame <= cmd.last;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;

endmodule

@@ hdl/offset64_frame_receiver.sv @@
// Top level of the offset-64 frame receiver: controller plus datapath.
//
// Receive channel (rx_valid/rx_ready/rx_byte): one serial byte per request.
// Bytes are dropped until '#' opens a frame; after that every byte but a
// carriage return goes into a 64-entry frame store and into a 12-bit sum.
// rx_ready is high whenever the controller is idle, so a plain data byte is
// taken every cycle, even while a finished result still waits in the output
// register.
// Result channel (res_valid/res_ready and the result fields): a carriage
// return closes the frame. Short frames, bad checksums and overruns give one
// status request with last_of_frame set. A good frame gives three payload
// requests per full group of four characters, or one request with
// payload_valid low when there is no full group; the last one is marked.
// The checksum is checked in the cycle after the carriage return; each
// group then takes four store reads (one read port), a drain step and
// three output requests. The receive side is closed while this goes on.
// A stalled receiver holds the output register and the sequencer in place.
// Reset (arst_n low) empties the result register and returns to waiting for
// '#'; the frame store itself is not cleared.
module offset64_frame_receiver (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [7:0] frame_address,
	output logic [7:0] frame_command,
	output logic [7:0] payload_byte,
	output logic       payload_valid,
	output logic [1:0] frame_status,
	output logic       reset_request,
	output logic       last_of_frame
);
	import o64fr_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequence intake, frame close and result emission
	o64fr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// hold the frame, the sum and the result register
	o64fr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_byte       (rx_byte),
		.cmd           (cmd),
		.sts           (sts),
		.res_ready     (res_ready),
		.res_valid     (res_valid),
		.frame_address (frame_address),
		.frame_command (frame_command),
		.payload_byte  (payload_byte),
		.payload_valid (payload_valid),
		.frame_status  (frame_status),
		.reset_request (reset_request),
		.last_of_frame (last_of_frame)
	);

endmodule

@@ hdl/o64fr_chk.sv @@
// Port-level checker for the frame receiver, bound to the top level.
module o64fr_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       rx_valid,
	input logic       rx_ready,
	input logic [7:0] rx_byte,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] frame_address,
	input logic [7:0] frame_command,
	input logic [7:0] payload_byte,
	input logic       payload_valid,
	input logic [1:0] frame_status,
	input logic       reset_request,
	input logic       last_of_frame
);
	import o64fr_pkg::*;

	a_rx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rx_valid && !rx_ready |=> rx_valid && $stable(rx_byte))
		else $error("receive request withdrawn or changed while waiting");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(payload_byte)
			&& $stable(frame_status) && $stable(last_of_frame))
		else $error("result dropped or changed while stalled");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_status != ST_OK |-> last_of_frame && !payload_valid
			&& !reset_request && frame_address == 8'd0 && frame_command == 8'd0)
		else $error("status request not a clean final request");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !payload_valid |-> last_of_frame && payload_byte == 8'd0)
		else $error("request without payload is not final");

	a_reset_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && reset_request |-> frame_command == CH_RESET && frame_status == ST_OK)
		else $error("reset request without reset command");

endmodule

bind offset64_frame_receiver o64fr_chk u_o64fr_chk (.*);
